// ===== hdl/mbp_pkg.sv =====
package mbp_pkg;

    typedef enum logic [2:0] {
        ST_IGNORE,
        ST_STATUS,
        ST_SYSEX,
        ST_WAIT2,
        ST_WAIT1
    } parse_state_t;

    // Result kinds
    localparam logic [3:0] KIND_NOTE_OFF     = 4'd0;
    localparam logic [3:0] KIND_SONG_POS     = 4'd7;
    localparam logic [3:0] KIND_SYSEX_START  = 4'd8;
    localparam logic [3:0] KIND_SYSEX_DATA   = 4'd9;
    localparam logic [3:0] KIND_SYSEX_END    = 4'd10;
    localparam logic [3:0] KIND_SYSEX_ABORT  = 4'd11;

    // Message type index; voice types share their code with the result kind
    localparam logic [3:0] TYPE_NOTE_OFF     = 4'd0;
    localparam logic [3:0] TYPE_NOTE_ON      = 4'd1;
    localparam logic [3:0] TYPE_POLY_AT      = 4'd2;
    localparam logic [3:0] TYPE_CTRL_CHG     = 4'd3;
    localparam logic [3:0] TYPE_PROG_CHG     = 4'd4;
    localparam logic [3:0] TYPE_CHAN_PRESS   = 4'd5;
    localparam logic [3:0] TYPE_PITCH        = 4'd6;
    localparam logic [3:0] TYPE_MTC_QF       = 4'd7;
    localparam logic [3:0] TYPE_SONG_POS     = 4'd8;
    localparam logic [3:0] TYPE_SONG_SEL     = 4'd9;
    localparam logic [3:0] TYPE_TUNE_REQ     = 4'd10;
    localparam logic [3:0] TYPE_NONE         = 4'd11;
    localparam logic [3:0] VOICE_KINDS       = 4'd7;

    // Status bytes
    localparam logic [7:0] SB_NONE           = 8'h00;
    localparam logic [7:0] SB_NOTE_OFF       = 8'h80;
    localparam logic [7:0] SB_NOTE_ON        = 8'h90;
    localparam logic [7:0] SB_POLY_AT        = 8'hA0;
    localparam logic [7:0] SB_CTRL_CHG       = 8'hB0;
    localparam logic [7:0] SB_PROG_CHG       = 8'hC0;
    localparam logic [7:0] SB_CHAN_PRESS     = 8'hD0;
    localparam logic [7:0] SB_PITCH          = 8'hE0;
    localparam logic [7:0] SB_SYSEX_START    = 8'hF0;
    localparam logic [7:0] SB_MTC_QF         = 8'hF1;
    localparam logic [7:0] SB_SONG_POS       = 8'hF2;
    localparam logic [7:0] SB_SONG_SEL       = 8'hF3;
    localparam logic [7:0] SB_TUNE_REQ       = 8'hF6;
    localparam logic [7:0] SB_SYSEX_END      = 8'hF7;
    localparam logic [7:0] SB_REALTIME_BASE  = 8'hF8;

    localparam logic [3:0] SYSTEM_NIBBLE     = 4'hF;

    // Register map
    localparam logic REG_PARSER_ENABLE       = 1'b0;

    function automatic logic [3:0] type_lookup(input logic [7:0] key);
        logic [3:0] idx;
        case (key)
            SB_NOTE_OFF:   idx = TYPE_NOTE_OFF;
            SB_NOTE_ON:    idx = TYPE_NOTE_ON;
            SB_POLY_AT:    idx = TYPE_POLY_AT;
            SB_CTRL_CHG:   idx = TYPE_CTRL_CHG;
            SB_PROG_CHG:   idx = TYPE_PROG_CHG;
            SB_CHAN_PRESS: idx = TYPE_CHAN_PRESS;
            SB_PITCH:      idx = TYPE_PITCH;
            SB_MTC_QF:     idx = TYPE_MTC_QF;
            SB_SONG_POS:   idx = TYPE_SONG_POS;
            SB_SONG_SEL:   idx = TYPE_SONG_SEL;
            SB_TUNE_REQ:   idx = TYPE_TUNE_REQ;
            default:       idx = TYPE_NONE;
        endcase
        return idx;
    endfunction

    // State that follows the status byte of a given type
    function automatic parse_state_t type_follow_state(input logic [3:0] idx);
        parse_state_t st;
        case (idx)
            TYPE_NOTE_OFF, TYPE_NOTE_ON, TYPE_POLY_AT, TYPE_CTRL_CHG,
            TYPE_PITCH, TYPE_SONG_POS:                 st = ST_WAIT2;
            TYPE_PROG_CHG, TYPE_CHAN_PRESS, TYPE_MTC_QF,
            TYPE_SONG_SEL:                             st = ST_WAIT1;
            TYPE_TUNE_REQ:                             st = ST_STATUS;
            default:                                   st = ST_IGNORE;
        endcase
        return st;
    endfunction

endpackage

// ===== hdl/midi_byte_parser.sv =====
// MIDI byte parser: takes one received byte per item and delivers one item per
// completed message (channel voice, song position, with running status; note-on
// at velocity zero comes out as note-off) and one per sysex start, data byte, end
// or abort. Realtime bytes are swallowed. It takes a byte in every cycle unless
// out_stall holds a valid result: the byte is registered, decoded against the small
// parse state in a single pass, and the result lands in the output register.
// out_stall holds the output register and backs up into the input register.
// Register 0 (parser_enable, reset 1) drops all non-realtime bytes when cleared.
module midi_byte_parser (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  message_kind,
    output logic [7:0]  status_byte,
    output logic [6:0]  data_first,
    output logic [6:0]  data_second
);

    // Config
    logic enable_reg;
    logic reg_sel;
    logic cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == mbp_pkg::REG_PARSER_ENABLE);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign prdata    = reg_sel ? {31'b0, enable_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            enable_reg <= 1'b1;
        end
        else if (cfg_write) begin
            enable_reg <= pwdata[0];
        end
    end

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       in_accept;

    assign advance   = in_valid_reg && !(out_valid && out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept) begin
            in_valid_reg <= 1'b1;
        end
        else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (in_accept) begin
            in_byte_reg <= rx_byte;
        end
    end

    // Parse state
    mbp_pkg::parse_state_t parse_state_reg, parse_state_next;
    logic [7:0] last_status_reg, last_status_next;
    logic [3:0] type_index_reg, type_index_next;
    logic [6:0] data_held_reg, data_held_next;

    logic proceed;
    logic is_data;

    assign proceed = advance && (in_byte_reg < mbp_pkg::SB_REALTIME_BASE) && enable_reg;
    assign is_data = !in_byte_reg[7];

    // Status-byte handling (also covers a data byte under running status)
    logic [7:0]            hs_last;
    logic [7:0]            hs_key;
    logic [3:0]            hs_type;
    logic [3:0]            hs_type_keep;
    mbp_pkg::parse_state_t hs_follow;
    mbp_pkg::parse_state_t hs_state;
    logic                  hs_no_status;
    logic                  hs_take;
    logic                  hs_start;
    logic                  hs_valid;
    logic [3:0]            hs_kind;
    logic [7:0]            hs_status;
    logic [6:0]            hs_d1;

    always_comb begin
        hs_start = (in_byte_reg == mbp_pkg::SB_SYSEX_START);
        if (hs_start) begin
            hs_last = mbp_pkg::SB_NONE;
        end
        else if (!is_data) begin
            hs_last = in_byte_reg;
        end
        else begin
            hs_last = last_status_reg;
        end
        // channel messages are looked up without their channel
        if (hs_last[7] && hs_last[7:4] != mbp_pkg::SYSTEM_NIBBLE) begin
            hs_key = {hs_last[7:4], 4'h0};
        end
        else begin
            hs_key = hs_last;
        end
        hs_type      = mbp_pkg::type_lookup(hs_key);
        hs_follow    = mbp_pkg::type_follow_state(hs_type);
        hs_no_status = is_data && (last_status_reg == mbp_pkg::SB_NONE);
        hs_type_keep = hs_no_status ? type_index_reg : hs_type;
        hs_take      = is_data && !hs_no_status
                       && (hs_follow == mbp_pkg::ST_WAIT2 || hs_follow == mbp_pkg::ST_WAIT1);

        if (hs_start) begin
            hs_state = mbp_pkg::ST_SYSEX;
        end
        else if (hs_no_status) begin
            hs_state = mbp_pkg::ST_STATUS;
        end
        else if (hs_take) begin
            hs_state = (hs_follow == mbp_pkg::ST_WAIT2) ? mbp_pkg::ST_WAIT1
                                                          : mbp_pkg::ST_STATUS;
        end
        else begin
            hs_state = hs_follow;
        end

        hs_valid  = hs_start
                    || (hs_take && hs_follow == mbp_pkg::ST_WAIT1
                        && hs_type < mbp_pkg::VOICE_KINDS);
        hs_kind   = hs_start ? mbp_pkg::KIND_SYSEX_START : hs_type;
        hs_status = hs_last;
        hs_d1     = hs_start ? 7'd0 : in_byte_reg[6:0];
    end

    // Last data byte of a message in WAIT1
    logic       td_two;
    logic       td_note_off;
    logic       td_valid;
    logic [3:0] td_kind;
    logic [6:0] td_d1;
    logic [6:0] td_d2;

    always_comb begin
        td_two      = (mbp_pkg::type_follow_state(type_index_reg) == mbp_pkg::ST_WAIT2);
        td_note_off = (type_index_reg == mbp_pkg::TYPE_NOTE_ON) && td_two
                      && (in_byte_reg[6:0] == 7'd0);
        td_valid    = (type_index_reg < mbp_pkg::VOICE_KINDS)
                      || (last_status_reg == mbp_pkg::SB_SONG_POS);
        if (td_note_off) begin
            td_kind = mbp_pkg::KIND_NOTE_OFF;
        end
        else if (type_index_reg < mbp_pkg::VOICE_KINDS) begin
            td_kind = type_index_reg;
        end
        else begin
            td_kind = mbp_pkg::KIND_SONG_POS;
        end
        td_d1 = td_two ? data_held_reg : in_byte_reg[6:0];
        td_d2 = td_two ? in_byte_reg[6:0] : 7'd0;
    end

    // Next state
    always_comb begin
        parse_state_next = parse_state_reg;
        if (proceed) begin
            case (parse_state_reg)
                mbp_pkg::ST_IGNORE:
                begin
                    if (!is_data) begin
                        parse_state_next = hs_state;
                    end
                end
                mbp_pkg::ST_SYSEX:
                begin
                    if (is_data || hs_start) begin
                        parse_state_next = mbp_pkg::ST_SYSEX;
                    end
                    else if (in_byte_reg == mbp_pkg::SB_SYSEX_END) begin
                        parse_state_next = mbp_pkg::ST_STATUS;
                    end
                    else begin
                        parse_state_next = hs_state;
                    end
                end
                mbp_pkg::ST_WAIT2:
                begin
                    parse_state_next = is_data ? mbp_pkg::ST_WAIT1 : hs_state;
                end
                mbp_pkg::ST_WAIT1:
                begin
                    parse_state_next = is_data ? mbp_pkg::ST_STATUS : hs_state;
                end
                default:
                begin
                    parse_state_next = hs_state;
                end
            endcase
        end
    end

    // Datapath and result
    logic       res_valid;
    logic [3:0] res_kind;
    logic [7:0] res_status;
    logic [6:0] res_d1;
    logic [6:0] res_d2;
    logic       apply_hs;

    always_comb begin
        last_status_next = last_status_reg;
        type_index_next  = type_index_reg;
        data_held_next   = data_held_reg;
        res_valid        = 1'b0;
        res_kind         = hs_kind;
        res_status       = hs_status;
        res_d1           = hs_d1;
        res_d2           = 7'd0;
        apply_hs         = 1'b0;

        if (proceed) begin
            case (parse_state_reg)
                mbp_pkg::ST_IGNORE:
                begin
                    apply_hs = !is_data;
                end
                mbp_pkg::ST_SYSEX:
                begin
                    res_valid  = 1'b1;
                    res_status = mbp_pkg::SB_NONE;
                    res_d1     = 7'd0;
                    if (is_data) begin
                        res_kind = mbp_pkg::KIND_SYSEX_DATA;
                        res_d1   = in_byte_reg[6:0];
                    end
                    else if (in_byte_reg == mbp_pkg::SB_SYSEX_END) begin
                        res_kind = mbp_pkg::KIND_SYSEX_END;
                    end
                    else begin
                        // a new sysex start only clears the last status
                        res_kind = mbp_pkg::KIND_SYSEX_ABORT;
                        if (hs_start) begin
                            last_status_next = mbp_pkg::SB_NONE;
                        end
                        else begin
                            last_status_next = hs_last;
                            type_index_next  = hs_type_keep;
                        end
                    end
                end
                mbp_pkg::ST_WAIT2:
                begin
                    if (is_data) begin
                        data_held_next = in_byte_reg[6:0];
                    end
                    else begin
                        apply_hs = 1'b1;
                    end
                end
                mbp_pkg::ST_WAIT1:
                begin
                    if (is_data) begin
                        res_valid  = td_valid;
                        res_kind   = td_kind;
                        res_status = last_status_reg;
                        res_d1     = td_d1;
                        res_d2     = td_d2;
                        if (td_note_off) begin
                            type_index_next = mbp_pkg::TYPE_NOTE_OFF;
                        end
                    end
                    else begin
                        apply_hs = 1'b1;
                    end
                end
                default:
                begin
                    apply_hs = 1'b1;
                end
            endcase

            if (apply_hs) begin
                last_status_next = hs_last;
                type_index_next  = hs_type_keep;
                res_valid        = hs_valid;
                if (hs_take && hs_follow == mbp_pkg::ST_WAIT2) begin
                    data_held_next = in_byte_reg[6:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            parse_state_reg <= mbp_pkg::ST_IGNORE;
            last_status_reg <= mbp_pkg::SB_NONE;
            type_index_reg  <= mbp_pkg::TYPE_NOTE_OFF;
        end
        else begin
            parse_state_reg <= parse_state_next;
            last_status_reg <= last_status_next;
            type_index_reg  <= type_index_next;
        end
    end

    always_ff @(posedge clk) begin
        data_held_reg <= data_held_next;
    end

    // Output register
    logic       out_valid_reg;
    logic [3:0] message_kind_reg;
    logic [7:0] status_byte_reg;
    logic [6:0] data_first_reg;
    logic [6:0] data_second_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= res_valid;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (advance && res_valid) begin
            message_kind_reg <= res_kind;
            status_byte_reg  <= res_status;
            data_first_reg   <= res_d1;
            data_second_reg  <= res_d2;
        end
    end

    assign out_valid    = out_valid_reg;
    assign message_kind = message_kind_reg;
    assign status_byte  = status_byte_reg;
    assign data_first   = data_first_reg;
    assign data_second  = data_second_reg;

endmodule

// ===== tb/midi_byte_parser_tb.sv =====
module midi_byte_parser_tb;
    import mbp_pkg::*;

    localparam logic [7:0] SB_UNDEF_1      = 8'hF4;
    localparam logic [7:0] SB_UNDEF_2      = 8'hF5;
    localparam logic [7:0] SB_REALTIME_TOP = 8'hFF;
    localparam logic [7:0] SB_VOICE_TOP    = 8'hEF;

    localparam int TOTAL_ITEMS  = 1950;
    localparam int PAUSE_AT     = 800;
    localparam int RECONFIG_AT  = 1300;
    localparam int CALM_TAIL    = 1650;
    localparam int FLUSH_CYCLES = 8;
    localparam int SCRIPT_LEN   = 32;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] status;
        logic [6:0] first;
        logic [6:0] second;
    } midi_msg_t;

    localparam midi_msg_t MSG_NONE = '0;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_RESULT,
        ROW_QUIET
    } row_kind_t;

    typedef struct {
        logic [7:0] rx;
        row_kind_t  how;
        midi_msg_t  want;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  message_kind;
    logic [7:0]  status_byte;
    logic [6:0]  data_first;
    logic [6:0]  data_second;

    // parser mirror
    logic         en_mirror;
    parse_state_t mirror_state;
    logic [7:0]   last_sb;
    logic [7:0]   msg_bytes [0:2];
    logic [1:0]   held;
    logic [3:0]   type_idx;

    midi_msg_t   pending_msgs [$];
    script_row_t script [0:SCRIPT_LEN-1];
    int          mismatches = 0;
    int          stream_count = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;

    midi_byte_parser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .message_kind (message_kind),
        .status_byte  (status_byte),
        .data_first   (data_first),
        .data_second  (data_second)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Data byte while one or two data bytes are awaited.
    function automatic bit absorb_data(input logic [7:0] b, output midi_msg_t m);
        logic [3:0] idx;
        logic [6:0] second;
        m = MSG_NONE;
        if (held < 2'd1 || held > 2'd2)
            held = 2'd1;
        msg_bytes[held] = b;
        held = held + 2'd1;
        if (mirror_state == ST_WAIT2)
        begin
            mirror_state = ST_WAIT1;
            return 1'b0;
        end
        mirror_state = ST_STATUS;
        idx = type_idx;
        second = (held == 2'd3) ? msg_bytes[2][6:0] : 7'd0;
        // note-on at velocity zero turns into note-off, status kept
        if (idx == TYPE_NOTE_ON && held == 2'd3 && msg_bytes[2] == 8'd0)
        begin
            idx = TYPE_NOTE_OFF;
            type_idx = TYPE_NOTE_OFF;
        end
        if (idx < VOICE_KINDS)
        begin
            m = {idx, msg_bytes[0], msg_bytes[1][6:0], second};
            return 1'b1;
        end
        if (msg_bytes[0] == SB_SONG_POS)
        begin
            m = {KIND_SONG_POS, msg_bytes[0], msg_bytes[1][6:0], second};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit start_status(input logic [7:0] b, output midi_msg_t m);
        logic         running;
        logic [7:0]   key;
        logic [3:0]   idx;
        parse_state_t nxt;
        m = MSG_NONE;
        if (b == SB_SYSEX_START)
        begin
            mirror_state = ST_SYSEX;
            last_sb = SB_NONE;
            m = {KIND_SYSEX_START, SB_NONE, 7'd0, 7'd0};
            return 1'b1;
        end
        if (b[7])
        begin
            last_sb = b;
            running = 1'b0;
        end
        else
        begin
            if (last_sb == SB_NONE)
                return 1'b0;
            running = 1'b1;
        end
        key = last_sb;
        if (key[7:4] != SYSTEM_NIBBLE)
            key[3:0] = 4'h0;
        case (key)
            SB_NOTE_OFF:   begin idx = TYPE_NOTE_OFF;   nxt = ST_WAIT2;  end
            SB_NOTE_ON:    begin idx = TYPE_NOTE_ON;    nxt = ST_WAIT2;  end
            SB_POLY_AT:    begin idx = TYPE_POLY_AT;    nxt = ST_WAIT2;  end
            SB_CTRL_CHG:   begin idx = TYPE_CTRL_CHG;   nxt = ST_WAIT2;  end
            SB_PROG_CHG:   begin idx = TYPE_PROG_CHG;   nxt = ST_WAIT1;  end
            SB_CHAN_PRESS: begin idx = TYPE_CHAN_PRESS; nxt = ST_WAIT1;  end
            SB_PITCH:      begin idx = TYPE_PITCH;      nxt = ST_WAIT2;  end
            SB_MTC_QF:     begin idx = TYPE_MTC_QF;     nxt = ST_WAIT1;  end
            SB_SONG_POS:   begin idx = TYPE_SONG_POS;   nxt = ST_WAIT2;  end
            SB_SONG_SEL:   begin idx = TYPE_SONG_SEL;   nxt = ST_WAIT1;  end
            SB_TUNE_REQ:   begin idx = TYPE_TUNE_REQ;   nxt = ST_STATUS; end
            default:       begin idx = TYPE_NONE;       nxt = ST_IGNORE; end
        endcase
        type_idx = idx;
        if (idx == TYPE_NONE)
        begin
            mirror_state = ST_IGNORE;
            return 1'b0;
        end
        mirror_state = nxt;
        msg_bytes[0] = last_sb;
        held = 2'd1;
        if (!running || mirror_state == ST_STATUS)
            return 1'b0;
        return absorb_data(b, m);
    endfunction

    function automatic bit decode_midi_byte(input logic [7:0] b, output midi_msg_t m);
        midi_msg_t scratch;
        bit        unused;
        m = MSG_NONE;
        if (b >= SB_REALTIME_BASE || !en_mirror)
            return 1'b0;
        case (mirror_state)
            ST_IGNORE:
            begin
                if (!b[7])
                    return 1'b0;
                mirror_state = ST_STATUS;
                return start_status(b, m);
            end
            ST_SYSEX:
            begin
                if (!b[7])
                begin
                    m = {KIND_SYSEX_DATA, SB_NONE, b[6:0], 7'd0};
                    return 1'b1;
                end
                if (b == SB_SYSEX_END)
                begin
                    mirror_state = ST_STATUS;
                    m = {KIND_SYSEX_END, SB_NONE, 7'd0, 7'd0};
                    return 1'b1;
                end
                // a new sysex restarts in place; any other status is parsed after the abort
                if (b == SB_SYSEX_START)
                    last_sb = SB_NONE;
                else
                begin
                    mirror_state = ST_STATUS;
                    unused = start_status(b, scratch);
                end
                m = {KIND_SYSEX_ABORT, SB_NONE, 7'd0, 7'd0};
                return 1'b1;
            end
            ST_WAIT2, ST_WAIT1:
            begin
                if (b[7])
                begin
                    mirror_state = ST_STATUS;
                    return start_status(b, m);
                end
                return absorb_data(b, m);
            end
            default:
            begin
                mirror_state = ST_STATUS;
                return start_status(b, m);
            end
        endcase
    endfunction

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (calm)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        midi_msg_t got;
        midi_msg_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {message_kind, status_byte, data_first, data_second};
            if (pending_msgs.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item: expected none, got kind %0d status %h %h %h",
                         $time, got.kind, got.status, got.first, got.second);
            end
            else
            begin
                want = pending_msgs.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    $display("%0t: mismatch: exp kind %0d st %h %h %h, got kind %0d st %h %h %h",
                             $time, want.kind, want.status, want.first, want.second,
                             got.kind, got.status, got.first, got.second);
                end
            end
        end
    end

    task automatic feed_byte(input logic [7:0] b, input row_kind_t how, input midi_msg_t want);
        midi_msg_t guess;
        bit        hit;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        hit = decode_midi_byte(b, guess);
        if (how == ROW_RESULT)
            pending_msgs.push_back(want);
        else if (how == ROW_PREDICT && hit)
            pending_msgs.push_back(guess);
        @(negedge clk);
    endtask

    task automatic stream_byte(input logic [7:0] b);
        if ($urandom_range(0, 15) == 0)
            feed_byte(8'($urandom_range(SB_REALTIME_BASE, SB_REALTIME_TOP)),
                      ROW_PREDICT, MSG_NONE);
        feed_byte(b, ROW_PREDICT, MSG_NONE);
        if (en_mirror)
            stream_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_msgs.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic set_parser_enable(input bit on);
        logic [31:0] word;
        drain_results();
        repeat (FLUSH_CYCLES) @(negedge clk);
        word = $urandom();
        word[0] = on;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_PARSER_ENABLE, 2'b00};
        pwdata <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        en_mirror = on;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [7:0] any_data();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic int voice_data_count(input logic [7:0] st);
        if (st[7:4] == SB_PROG_CHG[7:4] || st[7:4] == SB_CHAN_PRESS[7:4])
            return 1;
        return 2;
    endfunction

    task automatic random_sequence();
        logic [7:0] st;
        int         span;
        if (stream_count >= CALM_TAIL)
            calm = 1'b1;
        else if ($urandom_range(0, 29) == 0)
            calm = !calm;
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6:
            begin
                st = 8'($urandom_range(SB_NOTE_OFF, SB_VOICE_TOP));
                span = voice_data_count(st);
                stream_byte(st);
                // running status repeats
                repeat ($urandom_range(1, 4))
                    for (int k = 0; k < span; k++)
                        if (k == 1 && st[7:4] == SB_NOTE_ON[7:4] && $urandom_range(0, 3) == 0)
                            stream_byte(8'h00);
                        else
                            stream_byte(any_data());
            end
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       begin st = SB_MTC_QF;   span = 1; end
                    1:       begin st = SB_SONG_POS; span = 2; end
                    2:       begin st = SB_SONG_SEL; span = 1; end
                    default: begin st = SB_TUNE_REQ; span = 1; end
                endcase
                stream_byte(st);
                repeat ($urandom_range(1, 3))
                    repeat (span) stream_byte(any_data());
            end
            8, 9, 10:
            begin
                stream_byte(SB_SYSEX_START);
                repeat ($urandom_range(0, 8)) stream_byte(any_data());
                case ($urandom_range(0, 9))
                    7:       stream_byte(SB_SYSEX_START);
                    8:       stream_byte(8'($urandom_range(SB_NOTE_OFF, SB_VOICE_TOP)));
                    9:       stream_byte(8'($urandom_range(SB_MTC_QF, SB_SYSEX_END)));
                    default: stream_byte(SB_SYSEX_END);
                endcase
            end
            11:
            begin
                // cut short by the next status
                st = 8'($urandom_range(SB_NOTE_OFF, SB_VOICE_TOP));
                stream_byte(st);
                repeat (voice_data_count(st) - 1) stream_byte(any_data());
            end
            12:
            begin
                case ($urandom_range(0, 2))
                    0:       stream_byte(SB_UNDEF_1);
                    1:       stream_byte(SB_UNDEF_2);
                    default: stream_byte(SB_SYSEX_END);
                endcase
                repeat ($urandom_range(0, 3)) stream_byte(any_data());
            end
            default:
                repeat ($urandom_range(1, 4)) stream_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic random_until(input int target);
        while (stream_count < target)
            random_sequence();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        rx_byte = 8'h00;

        en_mirror = 1'b1;
        mirror_state = ST_IGNORE;
        last_sb = SB_NONE;
        msg_bytes = '{default: 8'h00};
        held = 2'd0;
        type_idx = TYPE_NOTE_OFF;

        script = '{
            '{8'h45,               ROW_QUIET,   MSG_NONE},
            '{SB_NOTE_ON,          ROW_QUIET,   MSG_NONE},
            '{8'h3C,               ROW_PREDICT, MSG_NONE},
            '{SB_REALTIME_TOP,     ROW_QUIET,   MSG_NONE},
            '{8'h7F,               ROW_RESULT,  '{TYPE_NOTE_ON, SB_NOTE_ON, 7'h3C, 7'h7F}},
            '{8'h3C,               ROW_PREDICT, MSG_NONE},
            '{8'h00,               ROW_RESULT,  '{KIND_NOTE_OFF, SB_NOTE_ON, 7'h3C, 7'h00}},
            '{SB_PROG_CHG | 8'h0F, ROW_QUIET,   MSG_NONE},
            '{8'h7F,               ROW_RESULT,
              '{TYPE_PROG_CHG, SB_PROG_CHG | 8'h0F, 7'h7F, 7'h00}},
            '{SB_PITCH | 8'h03,    ROW_QUIET,   MSG_NONE},
            '{8'h00,               ROW_PREDICT, MSG_NONE},
            '{SB_CTRL_CHG | 8'h02, ROW_QUIET,   MSG_NONE},
            '{8'h07,               ROW_PREDICT, MSG_NONE},
            '{8'h40,               ROW_PREDICT, MSG_NONE},
            '{SB_SONG_POS,         ROW_QUIET,   MSG_NONE},
            '{8'h10,               ROW_PREDICT, MSG_NONE},
            '{8'h20,               ROW_RESULT,  '{KIND_SONG_POS, SB_SONG_POS, 7'h10, 7'h20}},
            '{SB_MTC_QF,           ROW_PREDICT, MSG_NONE},
            '{8'h05,               ROW_PREDICT, MSG_NONE},
            '{SB_TUNE_REQ,         ROW_PREDICT, MSG_NONE},
            '{8'h11,               ROW_PREDICT, MSG_NONE},
            '{SB_UNDEF_1,          ROW_QUIET,   MSG_NONE},
            '{8'h22,               ROW_QUIET,   MSG_NONE},
            '{SB_SYSEX_START,      ROW_RESULT,  '{KIND_SYSEX_START, SB_NONE, 7'h00, 7'h00}},
            '{8'h7F,               ROW_RESULT,  '{KIND_SYSEX_DATA, SB_NONE, 7'h7F, 7'h00}},
            '{SB_SYSEX_START,      ROW_RESULT,  '{KIND_SYSEX_ABORT, SB_NONE, 7'h00, 7'h00}},
            '{SB_SYSEX_END,        ROW_RESULT,  '{KIND_SYSEX_END, SB_NONE, 7'h00, 7'h00}},
            '{SB_SYSEX_START,      ROW_PREDICT, MSG_NONE},
            '{SB_POLY_AT | 8'h04,  ROW_RESULT,  '{KIND_SYSEX_ABORT, SB_NONE, 7'h00, 7'h00}},
            '{SB_SONG_SEL,         ROW_PREDICT, MSG_NONE},
            '{8'h02,               ROW_PREDICT, MSG_NONE},
            '{SB_SYSEX_END,        ROW_PREDICT, MSG_NONE}
        };

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            feed_byte(script[i].rx, script[i].how, script[i].want);

        // disabled: all bytes are dropped (realtime ones always are), state held
        set_parser_enable(1'b0);
        repeat (30) stream_byte(8'($urandom_range(0, 255)));
        set_parser_enable(1'b1);

        random_until(PAUSE_AT);
        drain_results();
        random_until(RECONFIG_AT);

        set_parser_enable(1'b0);
        repeat (20) stream_byte(8'($urandom_range(0, 255)));
        set_parser_enable(1'b1);

        random_until(TOTAL_ITEMS);
        drain_results();
        repeat (FLUSH_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
